>>> sv/mams_pkg.sv
package mams_pkg;

	// Command codes; code 7 is a no-op
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_HALT = 3'd1;
	localparam logic [2:0] CMD_SETVEL = 3'd2;
	localparam logic [2:0] CMD_GOTO = 3'd3;
	localparam logic [2:0] CMD_HOMING = 3'd4;
	localparam logic [2:0] CMD_REZERO = 3'd5;
	localparam logic [2:0] CMD_LOAD = 3'd6;

	// Divisor choice of the shared reciprocal unit
	typedef enum logic {
		DIV_TICK,	// divide by 50 (one 0.02 s step)
		DIV_DEG		// divide by 360 (degrees to revolutions)
	} div_sel_t;

	// Motion state of one axis, Q16.16
	typedef struct packed {
		logic signed [31:0] pos;
		logic signed [31:0] vel;
		logic signed [31:0] tgt;
		logic               tact;
	} mams_axis_t;

endpackage

>>> sv/mams_recip_div.sv
module mams_recip_div (
	input  logic               clk,
	input  logic [31:0]        mag,
	input  mams_pkg::div_sel_t sel,
	output logic [31:0]        quo_s1
);

	// ceil(2^38/50) and ceil(2^41/360): exact floor quotients for mag <= 2^32-1
	localparam logic [32:0] RECIP_50 = 33'd5497558139;
	localparam logic [32:0] RECIP_360 = 33'd6108397933;

	logic [64:0] prod;

	assign prod = 65'(mag) * 65'((sel == mams_pkg::DIV_DEG) ? RECIP_360 : RECIP_50);

	always_ff @(posedge clk) begin
		if (sel == mams_pkg::DIV_DEG) begin
			quo_s1 <= 32'(prod[64:41]);
		end else begin
			quo_s1 <= 32'(prod[64:38]);
		end
	end

endmodule

>>> sv/mams_axis_step.sv
module mams_axis_step (
	input  mams_pkg::mams_axis_t cur,
	input  logic signed [31:0]   tmin,
	input  logic signed [31:0]   tmax,
	input  logic [31:0]          quo,
	output mams_pkg::mams_axis_t nxt
);

	logic signed [33:0] p, t, d, absd, qx, pn, mn, mx;
	logic signed [31:0] v;
	logic               ta;

	always_comb begin
		p = {{2{cur.pos[31]}}, cur.pos};
		t = {{2{cur.tgt[31]}}, cur.tgt};
		mn = {{2{tmin[31]}}, tmin};
		mx = {{2{tmax[31]}}, tmax};
		qx = {2'b00, quo};
		d = t - p;
		absd = d[33] ? -d : d;
		v = cur.vel;
		ta = cur.tact;
		if (cur.tact) begin
			if (absd <= qx) begin
				// arrive exactly and stop
				pn = t;
				ta = 1'b0;
				v = '0;
			end else begin
				pn = d[33] ? (p - qx) : (p + qx);
			end
		end else begin
			pn = cur.vel[31] ? (p - qx) : (p + qx);
		end
		if (pn <= mn) begin
			pn = mn;
			if (v < 0) begin
				v = '0;
			end
		end
		if (pn >= mx) begin
			pn = mx;
			if (v > 0) begin
				v = '0;
			end
		end
		nxt.pos = pn[31:0];
		nxt.vel = v;
		nxt.tgt = cur.tgt;
		nxt.tact = ta;
	end

endmodule

>>> sv/multi_axis_motion_simulator.sv
// Tick: busy from the accepting edge until the last axis reports; axis reports come out
// one per cycle once the first axis has left the divider, the last with busy already low.
// Other commands: busy through ST_CMD_DIV and ST_CMD_APPLY; a new command is taken only when idle.
// The sweep timing follows from the single reciprocal multiplier, used once per axis.
// Reports are strobed for one cycle each; the receiver cannot stall them.
// Reset (arst_n low, asynchronous) zeroes every axis state, limit and the sequencer.
module multi_axis_motion_simulator #(
	parameter int AXIS_COUNT = 7,
	parameter int EE_AXIS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         command,
	input  logic [2:0]         axis,
	input  logic               all_axes,
	input  logic               pos_valid,
	input  logic signed [31:0] pos_value,
	input  logic               vel_valid,
	input  logic signed [31:0] vel_value,
	input  logic signed [31:0] limit_low,
	input  logic signed [31:0] limit_high,
	input  logic [30:0]        speed_cap,
	input  logic signed [31:0] home_speed,
	output logic               result_valid,
	output logic [2:0]         axis_id,
	output logic signed [31:0] position,
	output logic signed [31:0] velocity,
	output logic               last
);

	localparam int IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int CNT_W = $clog2(AXIS_COUNT + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AXIS_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD_DIV,
		ST_CMD_APPLY,
		ST_TICK
	} state_t;

	state_t state_q;

	// Captured command beat
	logic [2:0]         cmd_q;
	logic [2:0]         axis_q;
	logic               all_q;
	logic               pvalid_q;
	logic signed [31:0] pval_q;
	logic               vvalid_q;
	logic signed [31:0] vval_q;
	logic signed [31:0] lim_lo_q;
	logic signed [31:0] lim_hi_q;
	logic [30:0]        cap_in_q;
	logic signed [31:0] home_in_q;

	// Per-axis state
	logic signed [31:0] pos_q [AXIS_COUNT];
	logic signed [31:0] vel_q [AXIS_COUNT];
	logic signed [31:0] tgt_q [AXIS_COUNT];
	logic               tact_q [AXIS_COUNT];
	logic signed [31:0] tmin_q [AXIS_COUNT];
	logic signed [31:0] tmax_q [AXIS_COUNT];
	logic [30:0]        vcap_q [AXIS_COUNT];
	logic signed [31:0] hvel_q [AXIS_COUNT];

	// Tick sweep: issue counter, then one stage in step with the divider output
	logic [CNT_W-1:0]   iss_q;
	logic               issue;
	logic [IDX_W-1:0]   rd_idx;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic signed [31:0] vel_s1;

	// Shared divider
	logic [31:0]        div_mag;
	mams_pkg::div_sel_t div_sel;
	logic [31:0]        quo_s1;

	mams_pkg::mams_axis_t cur_ax, nxt_ax;

	// Command decode
	logic [3:0]           ax4;
	logic [IDX_W-1:0]     cmd_idx;
	logic                 ax_ok;
	logic [AXIS_COUNT-1:0] hit;
	logic [31:0]          cap_sel;
	logic [31:0]          spd_mag;

	assign busy = (state_q != ST_IDLE);

	// Issue one axis per cycle until every axis has entered the divider
	assign issue = (state_q == ST_TICK) && (iss_q < CNT_W'(AXIS_COUNT));
	assign rd_idx = issue ? iss_q[IDX_W-1:0] : '0;

	// Share the multiplier: |velocity|/50 during a tick, |vel_value|/360 otherwise
	always_comb begin
		if (state_q == ST_TICK) begin
			div_sel = mams_pkg::DIV_TICK;
			div_mag = vel_q[rd_idx][31] ? 32'(-vel_q[rd_idx]) : 32'(vel_q[rd_idx]);
		end else begin
			div_sel = mams_pkg::DIV_DEG;
			div_mag = vval_q[31] ? 32'(-vval_q) : 32'(vval_q);
		end
	end

	mams_recip_div u_div (
		.clk    (clk),
		.mag    (div_mag),
		.sel    (div_sel),
		.quo_s1 (quo_s1)
	);

	// Gather the axis in the second slot of the sweep
	always_comb begin
		cur_ax.pos = pos_q[idx_s1];
		cur_ax.vel = vel_s1;
		cur_ax.tgt = tgt_q[idx_s1];
		cur_ax.tact = tact_q[idx_s1];
	end

	mams_axis_step u_step (
		.cur  (cur_ax),
		.tmin (tmin_q[idx_s1]),
		.tmax (tmax_q[idx_s1]),
		.quo  (quo_s1),
		.nxt  (nxt_ax)
	);

	// Decode the addressed axis; numbers at or above AXIS_COUNT match nothing
	assign ax4 = 4'(axis_q);
	assign cmd_idx = ax4[IDX_W-1:0];
	assign ax_ok = (5'(axis_q) < 5'(AXIS_COUNT));

	always_comb begin
		for (int a = 0; a < AXIS_COUNT; a++) begin
			hit[a] = ax_ok && (cmd_idx == IDX_W'(a));
		end
	end

	// Go-to speed: requested speed when below the cap, else the cap
	assign cap_sel = ax_ok ? {1'b0, vcap_q[cmd_idx]} : '0;
	assign spd_mag = (quo_s1 < cap_sel) ? quo_s1 : cap_sel;

	// Sequencer, sweep stage and report registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iss_q <= '0;
			v_s1 <= 1'b0;
			idx_s1 <= '0;
			vel_s1 <= '0;
			result_valid <= 1'b0;
			axis_id <= '0;
			position <= '0;
			velocity <= '0;
			last <= 1'b0;
			cmd_q <= '0;
			axis_q <= '0;
			all_q <= 1'b0;
			pvalid_q <= 1'b0;
			pval_q <= '0;
			vvalid_q <= 1'b0;
			vval_q <= '0;
			lim_lo_q <= '0;
			lim_hi_q <= '0;
			cap_in_q <= '0;
			home_in_q <= '0;
		end else begin
			result_valid <= 1'b0;
			last <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						// capture the whole beat
						cmd_q <= command;
						axis_q <= axis;
						all_q <= all_axes;
						pvalid_q <= pos_valid;
						pval_q <= pos_value;
						vvalid_q <= vel_valid;
						vval_q <= vel_value;
						lim_lo_q <= limit_low;
						lim_hi_q <= limit_high;
						cap_in_q <= speed_cap;
						home_in_q <= home_speed;
						iss_q <= '0;
						v_s1 <= 1'b0;
						state_q <= (command == mams_pkg::CMD_TICK) ? ST_TICK : ST_CMD_DIV;
					end
				end
				ST_CMD_DIV: begin
					// divider converts degrees to revolutions this cycle
					state_q <= ST_CMD_APPLY;
				end
				ST_CMD_APPLY: begin
					state_q <= ST_IDLE;
				end
				ST_TICK: begin
					// advance the issue counter and the stage in step with the divider output
					v_s1 <= issue;
					if (issue) begin
						idx_s1 <= rd_idx;
						vel_s1 <= vel_q[rd_idx];
						iss_q <= iss_q + 1'b1;
					end
					// report the axis leaving the step unit
					if (v_s1) begin
						result_valid <= 1'b1;
						axis_id <= 3'(4'(idx_s1));
						position <= nxt_ax.pos;
						velocity <= nxt_ax.vel;
						last <= (idx_s1 == LAST_IDX);
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Axis state: written by the sweep or by an applied command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXIS_COUNT; a++) begin
				pos_q[a] <= '0;
				vel_q[a] <= '0;
				tgt_q[a] <= '0;
				tact_q[a] <= 1'b0;
				tmin_q[a] <= '0;
				tmax_q[a] <= '0;
				vcap_q[a] <= '0;
				hvel_q[a] <= '0;
			end
		end else begin
			for (int a = 0; a < AXIS_COUNT; a++) begin
				if (state_q == ST_TICK && v_s1 && idx_s1 == IDX_W'(a)) begin
					pos_q[a] <= nxt_ax.pos;
					vel_q[a] <= nxt_ax.vel;
					tact_q[a] <= nxt_ax.tact;
				end
				if (state_q == ST_CMD_APPLY) begin
					case (cmd_q)
						mams_pkg::CMD_HALT: begin
							if (all_q || hit[a]) begin
								vel_q[a] <= '0;
								tact_q[a] <= 1'b0;
							end
						end
						mams_pkg::CMD_SETVEL, mams_pkg::CMD_GOTO: begin
							if (hit[a]) begin
								if (cmd_q == mams_pkg::CMD_GOTO && pvalid_q) begin
									tgt_q[a] <= pval_q;
									tact_q[a] <= 1'b1;
									vel_q[a] <= vvalid_q ? spd_mag : cap_sel;
								end else if (vvalid_q) begin
									// clamp to +/- cap, keep the sign
									vel_q[a] <= vval_q[31] ? -spd_mag : spd_mag;
									tact_q[a] <= 1'b0;
								end
							end
						end
						mams_pkg::CMD_HOMING: begin
							if ((all_q && a != EE_AXIS) || (!all_q && hit[a])) begin
								tgt_q[a] <= '0;
								tact_q[a] <= 1'b1;
								vel_q[a] <= hvel_q[a];
							end
						end
						mams_pkg::CMD_REZERO: begin
							if (hit[a] && pvalid_q) begin
								pos_q[a] <= '0;
								vel_q[a] <= '0;
								tact_q[a] <= 1'b0;
							end
						end
						mams_pkg::CMD_LOAD: begin
							if (hit[a]) begin
								tmin_q[a] <= lim_lo_q;
								tmax_q[a] <= lim_hi_q;
								vcap_q[a] <= cap_in_q;
								hvel_q[a] <= home_in_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

`ifndef SYNTH
	// Reports only come out of a tick sweep
	a_report_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == ST_TICK))
		else $error("report outside a tick");

	// The final report closes the sweep
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("still busy after final report");

	// Reports of one tick run in axis order without gaps
	a_axis_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && axis_id == $past(axis_id) + 3'd1)
		else $error("axis reports out of order");

	// A non-tick command yields no report
	a_cmd_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command != mams_pkg::CMD_TICK |=> ##1 !result_valid)
		else $error("report after a non-tick command");
`endif

endmodule
